// ----- sv/shift_cipher_rle_compressor_macros.svh -----
// assertion macros for the shift cipher rle compressor rtl
// no dependencies; assertions fall away when SYNTHESIS is defined
`ifndef SHIFT_CIPHER_RLE_COMPRESSOR_MACROS_SVH
`define SHIFT_CIPHER_RLE_COMPRESSOR_MACROS_SVH
`ifndef SYNTHESIS
`define SCRLE_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define SCRLE_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SCRLE_ASSERT(lbl, clk, rst_n, prop, msg)
`define SCRLE_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

// ----- sv/scrle_pkg.sv -----
// shared types, constants and helper functions for the shift cipher rle compressor
// no dependencies
package scrle_pkg;

    localparam int CHAR_W             = 7;
    localparam int RUN_COUNT_BITS_DEF = 16;
    localparam int QUEUE_DEPTH        = 4;

    // floor(x / 10) == (x * RECIP_TEN) >> RECIP_SHIFT for every x below 2^32
    localparam logic [31:0] RECIP_TEN   = 32'hCCCC_CCCD;
    localparam int          RECIP_SHIFT = 35;

    localparam logic [CHAR_W-1:0] ASCII_ZERO = 7'h30;

    typedef struct packed {
        logic [CHAR_W-1:0] in_char;
        logic              in_last;
    } in_item_t;

    typedef struct packed {
        logic [CHAR_W-1:0] out_char;
        logic              out_last;
    } out_item_t;

    typedef struct packed {
        logic a;
        logic b;
    } q_push_t;

    typedef struct packed {
        logic room;
        logic not_empty;
    } q_status_t;

    // decimal digits needed for the largest value of a bits-wide counter
    function automatic int dec_digits(input int bits);
        longint unsigned v;
        int              n;
        v = (64'd1 << bits) - 64'd1;
        n = 0;
        while (v > 0)
        begin
            v = v / 10;
            n = n + 1;
        end
        return n;
    endfunction

endpackage

// ----- sv/scrle_front.sv -----
// front end: shift cipher, run tracking and run close commands into the queue
// depends on scrle_pkg
module scrle_front #(
    parameter  int RUN_COUNT_BITS = scrle_pkg::RUN_COUNT_BITS_DEF,
    localparam int CW             = scrle_pkg::CHAR_W + RUN_COUNT_BITS + 1
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_wr_en,
    input  logic [scrle_pkg::CHAR_W-1:0] cfg_wr_data,
    input  logic                        char_valid,
    output logic                        char_ready,
    input  scrle_pkg::in_item_t         char_data,
    input  scrle_pkg::q_status_t        q_status,
    output scrle_pkg::q_push_t          q_push,
    output logic [CW-1:0]               push_data_a,
    output logic [CW-1:0]               push_data_b
);

    localparam logic [RUN_COUNT_BITS-1:0] LEN_MAX = {RUN_COUNT_BITS{1'b1}};
    localparam logic [RUN_COUNT_BITS-1:0] LEN_ONE = RUN_COUNT_BITS'(1);

    logic [scrle_pkg::CHAR_W-1:0] shift_reg, shift_next;
    logic [scrle_pkg::CHAR_W-1:0] run_symbol_reg, run_symbol_next;
    logic [RUN_COUNT_BITS-1:0]    run_length_reg, run_length_next;
    logic                         run_open_reg, run_open_next;

    logic                         accept;
    logic [scrle_pkg::CHAR_W-1:0] sym_s;
    logic                         cont;
    logic                         close_a;
    logic [scrle_pkg::CHAR_W-1:0] cur_sym;
    logic [RUN_COUNT_BITS-1:0]    cur_len;

    assign char_ready = q_status.room;
    assign accept     = char_valid && char_ready;

    // 7-bit add wraps modulo 128
    assign sym_s   = char_data.in_char + shift_reg;
    assign cont    = run_open_reg && (sym_s == run_symbol_reg) && (run_length_reg != LEN_MAX);
    assign close_a = run_open_reg && !cont;
    assign cur_sym = cont ? run_symbol_reg : sym_s;
    assign cur_len = cont ? (run_length_reg + LEN_ONE) : LEN_ONE;

    // a closed run always goes first; the flushed run follows when both occur
    assign q_push.a    = accept && (close_a || char_data.in_last);
    assign q_push.b    = accept && close_a && char_data.in_last;
    assign push_data_a = close_a ? {run_symbol_reg, run_length_reg, 1'b0}
                                 : {cur_sym, cur_len, 1'b1};
    assign push_data_b = {cur_sym, cur_len, 1'b1};

    always_comb
    begin
        shift_next      = cfg_wr_en ? cfg_wr_data : shift_reg;
        run_symbol_next = run_symbol_reg;
        run_length_next = run_length_reg;
        run_open_next   = run_open_reg;
        if (accept)
        begin
            if (char_data.in_last)
            begin
                run_symbol_next = '0;
                run_length_next = '0;
                run_open_next   = 1'b0;
            end
            else
            begin
                run_symbol_next = cur_sym;
                run_length_next = cur_len;
                run_open_next   = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shift_reg      <= '0;
            run_symbol_reg <= '0;
            run_length_reg <= '0;
            run_open_reg   <= 1'b0;
        end
        else
        begin
            shift_reg      <= shift_next;
            run_symbol_reg <= run_symbol_next;
            run_length_reg <= run_length_next;
            run_open_reg   <= run_open_next;
        end
    end

endmodule

// ----- sv/scrle_queue.sv -----
// four-entry command queue between front and back, up to two pushes per cycle
// depends on scrle_pkg and shift_cipher_rle_compressor_macros.svh
`include "shift_cipher_rle_compressor_macros.svh"
module scrle_queue #(
    parameter  int RUN_COUNT_BITS = scrle_pkg::RUN_COUNT_BITS_DEF,
    localparam int CW             = scrle_pkg::CHAR_W + RUN_COUNT_BITS + 1
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  scrle_pkg::q_push_t   q_push,
    input  logic [CW-1:0]        push_data_a,
    input  logic [CW-1:0]        push_data_b,
    input  logic                 pop,
    output scrle_pkg::q_status_t q_status,
    output logic [CW-1:0]        head_data
);

    localparam int DEPTH = scrle_pkg::QUEUE_DEPTH;
    localparam int PW    = $clog2(DEPTH);
    localparam int NW    = $clog2(DEPTH + 1);

    logic [CW-1:0] slot_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [NW-1:0] count_reg, count_next;
    logic [NW-1:0] push_n;

    assign push_n = NW'(q_push.a) + NW'(q_push.b);

    assign q_status.room      = (count_reg <= NW'(DEPTH - 2));
    assign q_status.not_empty = (count_reg != '0);
    assign head_data          = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + push_n[PW-1:0];
        rd_ptr_next = rd_ptr_reg + PW'(pop);
        count_next  = count_reg + push_n - NW'(pop);
    end

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_slot
        always_ff @(posedge clk)
        begin
            if (q_push.a && (wr_ptr_reg == PW'(i)))
            begin
                slot_reg[i] <= push_data_a;
            end
            else if (q_push.b && ((wr_ptr_reg + PW'(1)) == PW'(i)))
            begin
                slot_reg[i] <= push_data_b;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    `SCRLE_ASSERT_ALWAYS(a_count_bound, clk, !rst_n || (count_reg <= NW'(DEPTH)), "queue count overflow")
    `SCRLE_ASSERT(a_no_pop_empty, clk, rst_n, pop |-> (count_reg != '0), "pop from empty queue")
    `SCRLE_ASSERT(a_push_lands, clk, rst_n, (q_push.a && !pop) |=> (count_reg != '0), "push lost")

endmodule

// ----- sv/scrle_back.sv -----
// back end: emits run character then, for runs longer than one, decimal run length, msd first
// depends on scrle_pkg; one shared reciprocal multiplier, used in a MUL then a DIV state per digit
module scrle_back #(
    parameter  int RUN_COUNT_BITS = scrle_pkg::RUN_COUNT_BITS_DEF,
    localparam int CW             = scrle_pkg::CHAR_W + RUN_COUNT_BITS + 1
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  scrle_pkg::q_status_t q_status,
    input  logic [CW-1:0]        head_data,
    output logic                 pop,
    output logic                 code_valid,
    input  logic                 code_ready,
    output scrle_pkg::out_item_t code_data
);

    localparam int N   = RUN_COUNT_BITS;
    localparam int PRW = N + 32;
    localparam int DW  = scrle_pkg::dec_digits(N);
    localparam int DIW = $clog2(DW);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_MUL  = 2'd1;
    localparam logic [1:0] ST_DIV  = 2'd2;
    localparam logic [1:0] ST_DIG  = 2'd3;

    logic [1:0]                   state_reg, state_next;
    logic                         last_reg, last_next;
    logic [N-1:0]                 x_reg, x_next;
    logic [PRW-1:0]               prod_reg;
    logic [DIW-1:0]               wr_reg, wr_next;
    logic [DIW-1:0]               ptr_reg, ptr_next;
    logic [3:0]                   digit_mem [DW];
    logic                         out_valid_reg, out_valid_next;
    logic [scrle_pkg::CHAR_W-1:0] out_char_reg, out_char_next;
    logic                         out_last_reg, out_last_next;

    logic [scrle_pkg::CHAR_W-1:0] h_sym;
    logic [N-1:0]                 h_len;
    logic                         h_last;
    logic                         can_emit;
    logic                         load_out;
    logic                         dig_we;
    logic [DIW-1:0]               dig_wa;
    logic [3:0]                   dig_wd;
    logic [PRW-1:0]               shifted;
    logic [N-1:0]                 quot;
    logic [N+3:0]                 tenq;
    logic [N+3:0]                 rem_w;

    assign h_sym  = head_data[CW-1 -: scrle_pkg::CHAR_W];
    assign h_len  = head_data[N:1];
    assign h_last = head_data[0];

    assign can_emit = !out_valid_reg || code_ready;

    // divide by ten through the registered reciprocal product
    assign shifted = prod_reg >> scrle_pkg::RECIP_SHIFT;
    assign quot    = shifted[N-1:0];
    assign tenq    = ((N+4)'(quot) << 3) + ((N+4)'(quot) << 1);
    assign rem_w   = (N+4)'(x_reg) - tenq;

    always_comb
    begin
        state_next    = state_reg;
        last_next     = last_reg;
        x_next        = x_reg;
        wr_next       = wr_reg;
        ptr_next      = ptr_reg;
        pop           = 1'b0;
        load_out      = 1'b0;
        out_char_next = out_char_reg;
        out_last_next = out_last_reg;
        dig_we        = 1'b0;
        dig_wa        = wr_reg;
        dig_wd        = rem_w[3:0];
        case (state_reg)
            ST_IDLE:
            begin
                if (q_status.not_empty && can_emit)
                begin
                    pop           = 1'b1;
                    load_out      = 1'b1;
                    out_char_next = h_sym;
                    out_last_next = h_last && (h_len == N'(1));
                    last_next     = h_last;
                    if (h_len >= N'(10))
                    begin
                        x_next     = h_len;
                        wr_next    = '0;
                        state_next = ST_MUL;
                    end
                    else if (h_len > N'(1))
                    begin
                        // single digit, no conversion
                        dig_we     = 1'b1;
                        dig_wa     = '0;
                        dig_wd     = h_len[3:0];
                        ptr_next   = '0;
                        state_next = ST_DIG;
                    end
                end
            end
            ST_MUL:
            begin
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                dig_we = 1'b1;
                x_next = quot;
                if (quot == '0)
                begin
                    ptr_next   = wr_reg;
                    state_next = ST_DIG;
                end
                else
                begin
                    wr_next    = wr_reg + DIW'(1);
                    state_next = ST_MUL;
                end
            end
            ST_DIG:
            begin
                if (can_emit)
                begin
                    load_out      = 1'b1;
                    out_char_next = scrle_pkg::ASCII_ZERO + {3'b000, digit_mem[ptr_reg]};
                    out_last_next = last_reg && (ptr_reg == '0);
                    if (ptr_reg == '0)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        ptr_next = ptr_reg - DIW'(1);
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
        out_valid_next = load_out ? 1'b1 : (code_ready ? 1'b0 : out_valid_reg);
    end

    assign code_valid         = out_valid_reg;
    assign code_data.out_char = out_char_reg;
    assign code_data.out_last = out_last_reg;

    always_ff @(posedge clk)
    begin
        prod_reg <= PRW'(x_reg) * PRW'(scrle_pkg::RECIP_TEN);
        if (dig_we)
        begin
            digit_mem[dig_wa] <= dig_wd;
        end
        if (load_out)
        begin
            out_char_reg <= out_char_next;
            out_last_reg <= out_last_next;
        end
        last_reg <= last_next;
        x_reg    <= x_next;
        wr_reg   <= wr_next;
        ptr_reg  <= ptr_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// ----- sv/shift_cipher_rle_compressor.sv -----
// Shift cipher with run-length compression. Characters are accepted at one per clock while
// the command queue has two free entries; each is shifted modulo 128 by the value written on
// cfg_wr_data, and runs of equal characters are closed into commands. The back end sends the
// run character, then for a run of 2 to 9 its single length digit, or for a longer run the
// digits from the shared divide-by-ten multiplier (a MUL and a DIV state per digit), msd first.
// Output is registered; a closed run enters the queue and then loads the output register.
// top level; depends on scrle_pkg, scrle_front, scrle_queue and scrle_back
module shift_cipher_rle_compressor #(
    parameter int RUN_COUNT_BITS = scrle_pkg::RUN_COUNT_BITS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_wr_en,
    input  logic [scrle_pkg::CHAR_W-1:0] cfg_wr_data,
    input  logic                         char_valid,
    output logic                         char_ready,
    input  scrle_pkg::in_item_t          char_data,
    output logic                         code_valid,
    input  logic                         code_ready,
    output scrle_pkg::out_item_t         code_data
);

    localparam int CW = scrle_pkg::CHAR_W + RUN_COUNT_BITS + 1;

    scrle_pkg::q_push_t   q_push;
    scrle_pkg::q_status_t q_status;
    logic [CW-1:0]        push_data_a;
    logic [CW-1:0]        push_data_b;
    logic [CW-1:0]        head_data;
    logic                 pop;

    scrle_front #(
        .RUN_COUNT_BITS (RUN_COUNT_BITS)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .char_valid  (char_valid),
        .char_ready  (char_ready),
        .char_data   (char_data),
        .q_status    (q_status),
        .q_push      (q_push),
        .push_data_a (push_data_a),
        .push_data_b (push_data_b)
    );

    scrle_queue #(
        .RUN_COUNT_BITS (RUN_COUNT_BITS)
    ) u_queue (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_push      (q_push),
        .push_data_a (push_data_a),
        .push_data_b (push_data_b),
        .pop         (pop),
        .q_status    (q_status),
        .head_data   (head_data)
    );

    scrle_back #(
        .RUN_COUNT_BITS (RUN_COUNT_BITS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_status   (q_status),
        .head_data  (head_data),
        .pop        (pop),
        .code_valid (code_valid),
        .code_ready (code_ready),
        .code_data  (code_data)
    );

endmodule
